@@ rtl/mlfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared constants, codes and types for the magic/length frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

    localparam int HEADER_BYTES    = 10;
    localparam int MAX_FRAME_BYTES = 4096;

    localparam int FILL_W = $clog2(HEADER_BYTES + 1);
    localparam int BODY_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int MAC_W  = 6;
    localparam int CHK_W  = $clog2(MAX_FRAME_BYTES + 1) + 2 > 18 ?
                            $clog2(MAX_FRAME_BYTES + 1) + 2 : 18;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 72;

    // register indexes
    localparam logic [1:0] REG_FIRST_MAGIC  = 2'd0;
    localparam logic [1:0] REG_SECOND_MAGIC = 2'd1;
    localparam logic [1:0] REG_AUTH_MASK    = 2'd2;
    localparam logic [1:0] REG_MAC_LENGTH   = 2'd3;

    localparam logic [7:0]       RST_FIRST_MAGIC  = 8'd170;
    localparam logic [7:0]       RST_SECOND_MAGIC = 8'd85;
    localparam logic [7:0]       RST_AUTH_MASK    = 8'd1;
    localparam logic [MAC_W-1:0] RST_MAC_LENGTH   = MAC_W'(16);

    // input mode
    localparam logic MODE_RECEIVE = 1'b0;
    localparam logic MODE_CLEAR   = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_MAC    = 2'd2;

    typedef struct packed {
        logic [7:0]       first_magic;
        logic [7:0]       second_magic;
        logic [7:0]       auth_flag_mask;
        logic [MAC_W-1:0] mac_length;
    } cfg_t;

    typedef struct packed {
        logic       push;
        logic       shift;
        logic       clear;
        logic [7:0] data;
    } hdr_ctrl_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              next_is_magic;
        logic [7:0]        magic2;
        logic [7:0]        version;
        logic [7:0]        flags;
        logic [31:0]       sequence_counter;
        logic [15:0]       body_length;
    } hdr_stat_t;

endpackage

@@ rtl/mlfd_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_cfg_regs
// APB register bank: magic bytes, MAC flag mask and MAC length.
// ----------------------------------------------------------------------------
module mlfd_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mlfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mlfd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mlfd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output mlfd_pkg::cfg_t                   cfg
);

    mlfd_pkg::cfg_t cfg_reg;
    mlfd_pkg::cfg_t cfg_next;
    logic [1:0]     reg_index;
    logic           wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel & penable & pwrite & pready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                mlfd_pkg::REG_FIRST_MAGIC:  cfg_next.first_magic    = pwdata[7:0];
                mlfd_pkg::REG_SECOND_MAGIC: cfg_next.second_magic   = pwdata[7:0];
                mlfd_pkg::REG_AUTH_MASK:    cfg_next.auth_flag_mask = pwdata[7:0];
                mlfd_pkg::REG_MAC_LENGTH:
                    cfg_next.mac_length = pwdata[mlfd_pkg::MAC_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            mlfd_pkg::REG_FIRST_MAGIC:  prdata = {24'd0, cfg_reg.first_magic};
            mlfd_pkg::REG_SECOND_MAGIC: prdata = {24'd0, cfg_reg.second_magic};
            mlfd_pkg::REG_AUTH_MASK:    prdata = {24'd0, cfg_reg.auth_flag_mask};
            mlfd_pkg::REG_MAC_LENGTH:
                prdata = {{(mlfd_pkg::APB_DATA_W - mlfd_pkg::MAC_W){1'b0}},
                          cfg_reg.mac_length};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_magic    <= mlfd_pkg::RST_FIRST_MAGIC;
            cfg_reg.second_magic   <= mlfd_pkg::RST_SECOND_MAGIC;
            cfg_reg.auth_flag_mask <= mlfd_pkg::RST_AUTH_MASK;
            cfg_reg.mac_length     <= mlfd_pkg::RST_MAC_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/mlfd_hdr_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_hdr_buf
// Header byte store with fill count, one-position shift for rescanning and
// the first-magic compare on the byte that moves to the head.
// ----------------------------------------------------------------------------
module mlfd_hdr_buf
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            first_magic,
    input  mlfd_pkg::hdr_ctrl_t   ctrl,
    output mlfd_pkg::hdr_stat_t   stat
);

    logic [7:0]                  store_reg [mlfd_pkg::HEADER_BYTES];
    logic [mlfd_pkg::FILL_W-1:0] fill_reg;
    logic [mlfd_pkg::FILL_W-1:0] fill_next;

    always_comb
    begin
        priority if (ctrl.clear)
            fill_next = '0;
        else if (ctrl.push)
            fill_next = fill_reg + mlfd_pkg::FILL_W'(1);
        else if (ctrl.shift)
            fill_next = fill_reg - mlfd_pkg::FILL_W'(1);
        else
            fill_next = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    // store payload: written at the fill position or shifted down one entry
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            store_reg[fill_reg] <= ctrl.data;
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < mlfd_pkg::HEADER_BYTES - 1; i++)
                store_reg[i] <= store_reg[i+1];
        end
    end

    assign stat.fill             = fill_reg;
    assign stat.next_is_magic    = (store_reg[1] == first_magic);
    assign stat.magic2           = store_reg[1];
    assign stat.version          = store_reg[2];
    assign stat.flags            = store_reg[3];
    assign stat.sequence_counter = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};
    assign stat.body_length      = {store_reg[9], store_reg[8]};

endmodule

@@ rtl/magic_length_frame_deframer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_length_frame_deframer_core
// Link byte deframer: hunts for the magic bytes, checks the 10-byte header
// and passes a descriptor, the body bytes and the MAC bytes downstream.
// ----------------------------------------------------------------------------
// usage
//   input stream: one transaction per link byte; tuser = mode (0 byte,
//   1 clear receiver), tdata = rx_byte
//   output stream: tuser = kind (header, body, mac), tlast = end of frame,
//   tdata = descriptor fields or the data byte
//   a body or mac byte, or a header byte that does not complete a header, is
//   taken in idle; its result is registered and shown the next cycle
//   the byte that completes a header moves to the header check state, where
//   the add-and-compare on the frame length and a second magic compare judge it
//   a bad header moves to a rescan: the held bytes shift one entry a cycle
//   through the head compare until a first magic byte leads or none is left
//   while the result register holds an untaken transaction, tready stays
//   low unless the receiver takes it in the same cycle
//   reset empties the header store and the frame counters and loads the
//   register defaults; registers keep their values across a clear item
// ----------------------------------------------------------------------------
module magic_length_frame_deframer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // apb configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mlfd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mlfd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mlfd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mlfd_pkg::S_DATA_W-1:0]       s_axis_tdata,  // rx_byte
    input  logic                                s_axis_tuser,  // mode
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // version, flags, sequence_counter, body_length, mac_present, data_byte
    output logic [mlfd_pkg::M_DATA_W-1:0]       m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,  // kind
    output logic                                m_axis_tlast   // frame_last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_RESCAN = 2'd2;

    mlfd_pkg::cfg_t      cfg;
    mlfd_pkg::hdr_ctrl_t hctrl;
    mlfd_pkg::hdr_stat_t hstat;

    logic [1:0]                  state_reg, state_next;
    logic                        in_frame_reg, in_frame_next;
    logic [mlfd_pkg::BODY_W-1:0] body_rem_reg, body_rem_next;
    logic [mlfd_pkg::MAC_W-1:0]  mac_rem_reg, mac_rem_next;

    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  out_kind_reg, out_kind_next;
    logic [mlfd_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;

    logic                        in_fire;
    logic [7:0]                  rx_byte;
    logic                        mac_present;
    logic [mlfd_pkg::MAC_W-1:0]  mac_count;
    logic [mlfd_pkg::CHK_W-1:0]  frame_bytes;
    logic                        header_bad;
    logic                        frame_open;

    mlfd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mlfd_hdr_buf u_hdr
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .first_magic (cfg.first_magic),
        .ctrl        (hctrl),
        .stat        (hstat)
    );

    assign s_axis_tready = (state_reg == ST_IDLE) & (~out_valid_reg | m_axis_tready);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign rx_byte       = s_axis_tdata;

    // header check
    assign mac_present = (hstat.flags & cfg.auth_flag_mask) != 8'd0;
    assign mac_count   = mac_present ? cfg.mac_length : '0;
    assign frame_bytes = mlfd_pkg::CHK_W'(mlfd_pkg::HEADER_BYTES)
                       + mlfd_pkg::CHK_W'(hstat.body_length)
                       + mlfd_pkg::CHK_W'(mac_count);
    assign header_bad  = (hstat.magic2 != cfg.second_magic)
                       | (frame_bytes > mlfd_pkg::CHK_W'(mlfd_pkg::MAX_FRAME_BYTES));
    assign frame_open  = (hstat.body_length != 16'd0) | (mac_count != '0);

    always_comb
    begin
        state_next     = state_reg;
        in_frame_next  = in_frame_reg;
        body_rem_next  = body_rem_reg;
        mac_rem_next   = mac_rem_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        hctrl          = '0;
        hctrl.data     = rx_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == mlfd_pkg::MODE_CLEAR)
                    begin
                        hctrl.clear   = 1'b1;
                        in_frame_next = 1'b0;
                        body_rem_next = '0;
                        mac_rem_next  = '0;
                    end
                    else if (in_frame_reg && body_rem_reg != '0)
                    begin
                        body_rem_next  = body_rem_reg - mlfd_pkg::BODY_W'(1);
                        out_valid_next = 1'b1;
                        out_kind_next  = mlfd_pkg::KIND_BODY;
                        out_data_next  = '0;
                        out_data_next[68:61] = rx_byte;
                        out_last_next  = (body_rem_reg == mlfd_pkg::BODY_W'(1))
                                       & (mac_rem_reg == '0);
                        if (out_last_next)
                            in_frame_next = 1'b0;
                    end
                    else if (in_frame_reg && mac_rem_reg != '0)
                    begin
                        mac_rem_next   = mac_rem_reg - mlfd_pkg::MAC_W'(1);
                        out_valid_next = 1'b1;
                        out_kind_next  = mlfd_pkg::KIND_MAC;
                        out_data_next  = '0;
                        out_data_next[68:61] = rx_byte;
                        out_last_next  = (mac_rem_reg == mlfd_pkg::MAC_W'(1));
                        if (out_last_next)
                            in_frame_next = 1'b0;
                    end
                    else
                    begin
                        in_frame_next = 1'b0;
                        if (hstat.fill != '0 || rx_byte == cfg.first_magic)
                        begin
                            hctrl.push = 1'b1;
                            if (hstat.fill == mlfd_pkg::FILL_W'(mlfd_pkg::HEADER_BYTES - 1))
                                state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (header_bad)
                begin
                    state_next = ST_RESCAN;
                end
                else
                begin
                    hctrl.clear    = 1'b1;
                    body_rem_next  = mlfd_pkg::BODY_W'(hstat.body_length);
                    mac_rem_next   = mac_count;
                    in_frame_next  = frame_open;
                    out_valid_next = 1'b1;
                    out_kind_next  = mlfd_pkg::KIND_HEADER;
                    out_data_next  = '0;
                    out_data_next[7:0]   = hstat.version;
                    out_data_next[15:8]  = hstat.flags;
                    out_data_next[47:16] = hstat.sequence_counter;
                    out_data_next[59:48] = hstat.body_length[11:0];
                    out_data_next[60]    = mac_present;
                    out_last_next  = ~frame_open;
                    state_next     = ST_IDLE;
                end
            end
            ST_RESCAN:
            begin
                // drop the head byte; stop on a first magic or the last byte
                hctrl.shift = 1'b1;
                if (hstat.fill == mlfd_pkg::FILL_W'(1) || hstat.next_is_magic)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_frame_reg  <= 1'b0;
            body_rem_reg  <= '0;
            mac_rem_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_frame_reg  <= in_frame_next;
            body_rem_reg  <= body_rem_next;
            mac_rem_reg   <= mac_rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // checks
    a_rescan_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RESCAN |-> hstat.fill != '0)
        else $error("rescan with empty header store");

    a_check_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> !out_valid_reg)
        else $error("header check while result register is occupied");

    a_frame_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (body_rem_reg != '0 || mac_rem_reg != '0))
        else $error("frame open with nothing left to pass");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hstat.fill <= mlfd_pkg::FILL_W'(mlfd_pkg::HEADER_BYTES))
        else $error("header fill beyond header size");

    a_check_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> hstat.fill == mlfd_pkg::FILL_W'(mlfd_pkg::HEADER_BYTES))
        else $error("header check without a full header");

endmodule
